@@ design/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/sid_pkg.sv @@
`default_nettype none
package sid_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   localparam logic [WIDTH-1:0] INT_MAX   = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } sid_ctrl_type;

endpackage
`default_nettype wire

@@ design/sid_cell.sv @@
`default_nettype none
// One bit slice of the divider: remainder bit, dividend/quotient bit and
// divisor bit, plus its stage of the trial-subtract borrow chain.
module sid_cell (
   input  logic               clock,
   input  sid_pkg::sid_ctrl_type ctl,
   input  logic               load_num,
   input  logic               load_div,
   input  logic               rem_shift,
   input  logic               num_shift,
   input  logic               borrow_in,
   input  logic               qbit,
   output logic               rem_out,
   output logic               num_out,
   output logic               borrow_out
);
   import sid_pkg::*;

   logic r_ff, n_ff, d_ff;
   logic r_in, n_in, d_in;
   logic diff;

   assign diff       = rem_shift ^ d_ff ^ borrow_in;
   assign borrow_out = (~rem_shift & d_ff) | (~(rem_shift ^ d_ff) & borrow_in);

   always_comb begin
      r_in = r_ff;
      n_in = n_ff;
      d_in = d_ff;
      if (ctl.load) begin
         r_in = 1'b0;
         n_in = load_num;
         d_in = load_div;
      end else if (ctl.step) begin
         // restore: keep the shifted value when the subtract went negative
         r_in = qbit ? diff : rem_shift;
         n_in = num_shift;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      n_ff <= n_in;
      d_ff <= d_in;
   end

   assign rem_out = r_ff;
   assign num_out = n_ff;

endmodule
`default_nettype wire

@@ design/sid_ctrl.sv @@
`default_nettype none
module sid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output sid_pkg::sid_ctrl_type ctl
);
   import sid_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               count_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ design/signed_int32_divider.sv @@
// Signed 32-bit divider, quotient truncated toward zero. A request is taken
// only while the divider is idle; it then runs one restoring shift-subtract
// step per cycle through a row of 32 bit-slice cells (the borrow ripples
// across the row each cycle), then writes the result register once it is
// free, and the next request can be taken the cycle after the result is
// written, so one item is in flight at a time. The result register
// lets a new request start while the previous result still waits. A zero
// divisor gives quotient 0 with divide_by_zero set; the most negative
// dividend over -1 saturates to the largest positive value.
`default_nettype none
module signed_int32_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sid_pkg::WIDTH-1:0]  req_dividend,
   input  logic signed [sid_pkg::WIDTH-1:0]  req_divisor,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sid_pkg::WIDTH-1:0]  rsp_quotient,
   output logic                              rsp_divide_by_zero
);
   import sid_pkg::*;

   sid_ctrl_type      ctl;
   logic [WIDTH-1:0]  a_mag, b_mag;
   logic [WIDTH-1:0]  rem_bits, num_bits, borrow;
   logic              qbit;
   logic              neg_ff, neg_in, zero_ff, zero_in;
   logic [WIDTH-1:0]  quot_ff, quot_in;
   logic              dbz_ff, dbz_in;
   logic [WIDTH-1:0]  result;

   sid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   assign a_mag = req_dividend[WIDTH-1] ? WIDTH'(-$unsigned(req_dividend))
                                        : $unsigned(req_dividend);
   assign b_mag = req_divisor[WIDTH-1]  ? WIDTH'(-$unsigned(req_divisor))
                                        : $unsigned(req_divisor);

   // no final borrow means the shifted remainder is at least the divisor
   assign qbit = ~borrow[WIDTH-1];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      if (i == 0) begin : g_lsb
         sid_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .load_num   (a_mag[i]),
            .load_div   (b_mag[i]),
            .rem_shift  (num_bits[WIDTH-1]),
            .num_shift  (qbit),
            .borrow_in  (1'b0),
            .qbit       (qbit),
            .rem_out    (rem_bits[i]),
            .num_out    (num_bits[i]),
            .borrow_out (borrow[i])
         );
      end else begin : g_upper
         sid_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .load_num   (a_mag[i]),
            .load_div   (b_mag[i]),
            .rem_shift  (rem_bits[i-1]),
            .num_shift  (num_bits[i-1]),
            .borrow_in  (borrow[i-1]),
            .qbit       (qbit),
            .rem_out    (rem_bits[i]),
            .num_out    (num_bits[i]),
            .borrow_out (borrow[i])
         );
      end
   end

   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = WIDTH'(-num_bits);
      end else if (num_bits[WIDTH-1]) begin
         result = INT_MAX;
      end else begin
         result = num_bits;
      end
   end

   always_comb begin
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;
      dbz_in  = dbz_ff;
      if (ctl.load) begin
         neg_in  = req_dividend[WIDTH-1] ^ req_divisor[WIDTH-1];
         zero_in = (req_divisor == '0);
      end
      if (ctl.finish) begin
         quot_in = result;
         dbz_in  = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
      dbz_ff  <= dbz_in;
   end

   assign rsp_quotient       = $signed(quot_ff);
   assign rsp_divide_by_zero = dbz_ff;

endmodule
`default_nettype wire

@@ design/sid_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module sid_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [sid_pkg::WIDTH-1:0]  rsp_quotient,
   input logic                              rsp_divide_by_zero
);
   import sid_pkg::*;

   // one item in flight: no request right after a request transfer
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // a new result is only written from the finishing step
   `ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))
   `ASSERT_IMPL(a_dbz_zero, clock, reset, rsp_valid && rsp_divide_by_zero,
                rsp_quotient == '0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_quotient) && $stable(rsp_divide_by_zero))

endmodule

bind signed_int32_divider sid_checker u_sid_checker (.*);
`default_nettype wire
